### hdl/svpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svpr_pkg: shared types and constants of the spectrum pixel renderer
// Sequencer states, controller/datapath command and status bundles, and
// the fixed constants of the distance and colour arithmetic.
// ---------------------------------------------------------------------------
package svpr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAND_WR,
        ST_ITER,
        ST_SHADE,
        ST_HSV_A,
        ST_HSV_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic band_wr;
        logic step;
        logic shade;
        logic hsv_a;
        logic hsv_b;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // transaction kinds carried on func
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // display_style codes
    localparam logic STYLE_BARS   = 1'b0;
    localparam logic STYLE_RADIAL = 1'b1;

    // integer square root: 12 two-bit steps over a 24-bit radicand
    localparam int SQRT_STEPS = 12;
    localparam int SQ_W       = 24;
    localparam int DIST_W     = 12;

    localparam logic [7:0] FULL_VALUE = 8'd255;
    localparam logic [7:0] GLOW_VALUE = 8'd50;
    localparam logic [7:0] EDGE_GAIN  = 8'd200;
    localparam int         HUE_SPAN   = 43;

endpackage : svpr_pkg
`default_nettype wire

### hdl/spectrum_visualizer_pixel_renderer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spectrum_visualizer_pixel_renderer_core: spectrum pixel renderer
// Band store plus pixel colour engine for a 16x16 bars or radial display.
//
// Input channel (in_valid/in_stall): func selects a band write or a pixel
// query. A band write is accepted and then stored in ST_BAND_WR; it returns
// nothing. A pixel query is accepted, latching the band average, then runs
// 12 steps of the distance root, shading and two HSV stages, and last moves
// the pixel into the output register. One transaction is worked at a time.
// Output channel (out_valid/out_stall): one pixel per query, held in an
// output register, so the next item is accepted while a pixel waits; a
// finished query waits in the sequencer only if that register is still
// full and stalled. The APB register display_style (address 0) picks bars
// or radial mode; the user must write it only while the block is idle, and
// the block itself does not enforce this. Reset clears the band valid bits
// (all bands then read zero), the total, the mode and the output valid.
// ---------------------------------------------------------------------------
module spectrum_visualizer_pixel_renderer_core #(
    parameter int BAND_COUNT  = 16,
    parameter int LEVEL_LIMIT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  band_index,
    input  logic [7:0]  band_level,
    input  logic [3:0]  pixel_x,
    input  logic [3:0]  pixel_y,
    input  logic [7:0]  hue_phase,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_red,
    output logic [7:0]  pixel_green,
    output logic [7:0]  pixel_blue,
    output logic        pixel_lit
);
    import svpr_pkg::*;

    localparam int STEP_COUNT = SQRT_STEPS;

    localparam logic REG_DISPLAY_STYLE = 1'b0;

    // ---------------- configuration register ----------------
    logic style_reg;
    logic style_next;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        style_next = style_reg;
        if (cfg_write && (paddr[2] == REG_DISPLAY_STYLE))
            style_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            style_reg <= STYLE_BARS;
        else
            style_reg <= style_next;
    end

    assign prdata = (paddr[2] == REG_DISPLAY_STYLE) ? {31'b0, style_reg} : '0;

    // ---------------- controller and datapath ----------------
    cmd_t    cmd;
    status_t status;

    svpr_ctrl #(
        .STEP_COUNT (STEP_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    svpr_dp #(
        .BAND_COUNT  (BAND_COUNT),
        .LEVEL_LIMIT (LEVEL_LIMIT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .display_style (style_reg),
        .func          (func),
        .band_index    (band_index),
        .band_level    (band_level),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .hue_phase     (hue_phase),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .pixel_red     (pixel_red),
        .pixel_green   (pixel_green),
        .pixel_blue    (pixel_blue),
        .pixel_lit     (pixel_lit)
    );

endmodule : spectrum_visualizer_pixel_renderer_core
`default_nettype wire

### hdl/svpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svpr_ctrl: sequencer of the spectrum pixel renderer
// Accepts one transaction at a time and steps the datapath through the
// band update or through the distance root iterations, shading and colour
// stages.
// ---------------------------------------------------------------------------
module svpr_ctrl #(
    parameter int STEP_COUNT = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              func,
    output logic              in_stall,
    input  svpr_pkg::status_t status,
    output svpr_pkg::cmd_t    cmd
);
    import svpr_pkg::*;

    localparam int CNT_W = $clog2(STEP_COUNT);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (func == FUNC_QUERY)
                        state_next = ST_ITER;
                    else
                        state_next = ST_BAND_WR;
                end
            end
            ST_BAND_WR:
            begin
                cmd.band_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_ITER:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == CNT_W'(STEP_COUNT - 1))
                    state_next = ST_SHADE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SHADE:
            begin
                cmd.shade  = 1'b1;
                state_next = ST_HSV_A;
            end
            ST_HSV_A:
            begin
                cmd.hsv_a  = 1'b1;
                state_next = ST_HSV_B;
            end
            ST_HSV_B:
            begin
                cmd.hsv_b  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the finished pixel until the output register frees up
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : svpr_ctrl
`default_nettype wire

### hdl/svpr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svpr_dp: datapath of the spectrum pixel renderer
// Band level memory and running total, reciprocal average, iterative
// square root, pixel shading, two-stage HSV to RGB and the output register.
// ---------------------------------------------------------------------------
module svpr_dp #(
    parameter int BAND_COUNT  = 16,
    parameter int LEVEL_LIMIT = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  svpr_pkg::cmd_t    cmd,
    output svpr_pkg::status_t status,
    input  logic              display_style,
    input  logic              func,
    input  logic [3:0]        band_index,
    input  logic [7:0]        band_level,
    input  logic [3:0]        pixel_x,
    input  logic [3:0]        pixel_y,
    input  logic [7:0]        hue_phase,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [7:0]        pixel_red,
    output logic [7:0]        pixel_green,
    output logic [7:0]        pixel_blue,
    output logic              pixel_lit
);
    import svpr_pkg::*;

    localparam int LW    = $clog2(LEVEL_LIMIT + 1);
    localparam int BW    = $clog2(BAND_COUNT);
    localparam int TW    = $clog2(BAND_COUNT * LEVEL_LIMIT + 1);
    localparam int XW    = ((BW > 4) ? BW : 4) + 1;
    localparam int RW    = LW + 7;
    localparam int CMP_W = ((RW > DIST_W) ? RW : DIST_W) + 2;

    // total / BAND_COUNT as (total * RECIP) >> RECIP_SH, exact for every total
    localparam int RECIP_SH = TW + BW;
    localparam int RECIP_W  = TW + 2;
    localparam int PROD_W   = TW + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(BAND_COUNT) - 64'd1) / 64'(BAND_COUNT));

    typedef enum logic [2:0] {
        SEC_RED,
        SEC_YELLOW,
        SEC_GREEN,
        SEC_CYAN,
        SEC_BLUE,
        SEC_MAGENTA
    } sector_t;

    // ---------------- input capture and band memory ----------------
    logic [XW-1:0]   idx_ext;
    logic [XW-1:0]   x_ext;
    logic            idx_ok;
    logic            x_ok;
    logic [BW-1:0]   rd_addr;
    logic [LW-1:0]   lvl_clamped;

    assign idx_ext     = XW'(band_index);
    assign x_ext       = XW'(pixel_x);
    assign idx_ok      = idx_ext < XW'(BAND_COUNT);
    assign x_ok        = x_ext < XW'(BAND_COUNT);
    assign lvl_clamped = (band_level > 8'(LEVEL_LIMIT)) ? LW'(LEVEL_LIMIT) : LW'(band_level);

    always_comb
    begin
        if (func == FUNC_QUERY)
            rd_addr = x_ok ? BW'(pixel_x) : '0;
        else
            rd_addr = idx_ok ? BW'(band_index) : '0;
    end

    logic [BW-1:0]   wr_addr_reg;
    logic            wr_ok_reg;
    logic [LW-1:0]   wr_lvl_reg;
    logic [3:0]      x_reg;
    logic [3:0]      y_reg;
    logic            x_ok_reg;
    logic [7:0]      phase_reg;
    logic [LW-1:0]   rd_data_reg;
    logic            rd_vld_reg;

    logic [LW-1:0]   band_mem [BAND_COUNT];
    logic [BAND_COUNT-1:0] vld_reg;
    logic [BAND_COUNT-1:0] vld_next;
    logic [TW-1:0]   total_reg;
    logic [TW-1:0]   total_next;
    logic [LW-1:0]   level;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wr_addr_reg <= rd_addr;
            wr_ok_reg   <= idx_ok;
            wr_lvl_reg  <= lvl_clamped;
            x_reg       <= pixel_x;
            y_reg       <= pixel_y;
            x_ok_reg    <= x_ok;
            phase_reg   <= hue_phase;
            rd_data_reg <= band_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
        if (cmd.band_wr && wr_ok_reg)
            band_mem[wr_addr_reg] <= wr_lvl_reg;
    end

    // never-written bands read as zero
    assign level = rd_vld_reg ? rd_data_reg : '0;

    always_comb
    begin
        vld_next   = vld_reg;
        total_next = total_reg;
        if (cmd.band_wr && wr_ok_reg)
        begin
            vld_next[wr_addr_reg] = 1'b1;
            total_next = total_reg - TW'(level) + TW'(wr_lvl_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            vld_reg   <= vld_next;
            total_reg <= total_next;
        end
    end

    // ---------------- band average and distance root ----------------
    logic [3:0]      ax;
    logic [3:0]      ay;
    logic [8:0]      sq_sum;
    logic [PROD_W-1:0] avg_prod;
    logic [LW-1:0]   avg_reg;
    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] root_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W-1:0] root_plus_bit;

    // |2x - 15| is odd: low three bits of x or their complement, then a one
    assign ax     = {pixel_x[3] ? pixel_x[2:0] : ~pixel_x[2:0], 1'b1};
    assign ay     = {pixel_y[3] ? pixel_y[2:0] : ~pixel_y[2:0], 1'b1};
    assign sq_sum = 9'(ax * ax) + 9'(ay * ay);

    assign avg_prod      = PROD_W'(total_reg) * PROD_W'(RECIP);
    assign root_plus_bit = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            avg_reg  <= avg_prod[RECIP_SH +: LW];
            n_reg    <= SQ_W'({sq_sum, 14'b0});
            root_reg <= '0;
            bit_reg  <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
        end
        else if (cmd.step)
        begin
            // digit-by-digit root; idle once the bit has run out
            if (bit_reg != '0)
            begin
                if (n_reg >= root_plus_bit)
                begin
                    n_reg    <= n_reg - root_plus_bit;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    // ---------------- shading ----------------
    logic [3:0]       row_up;
    logic [11:0]      hue_scaled;
    logic [LW-1:0]    avg;
    logic [CMP_W-1:0] rad_w;
    logic [CMP_W-1:0] dist_w;
    logic [7:0]       excess;
    logic [15:0]      edge_prod;
    logic             lit_s;
    logic [7:0]       hue_s;
    logic [7:0]       val_s;
    logic             lit_reg;
    logic [7:0]       hue_reg;
    logic [7:0]       val_reg;

    assign row_up     = ~y_reg;
    assign hue_scaled = {x_reg, 8'b0} - 12'(x_reg);
    assign avg        = avg_reg;
    assign rad_w      = CMP_W'({avg, 7'b0});
    assign dist_w     = CMP_W'(root_reg[DIST_W-1:0]);
    assign excess     = 8'(dist_w - rad_w);
    assign edge_prod  = 16'(excess) * 16'(EDGE_GAIN);

    always_comb
    begin
        lit_s = 1'b0;
        hue_s = '0;
        val_s = '0;
        if (display_style == STYLE_BARS)
        begin
            if (x_ok_reg && (9'(row_up) < 9'(level)))
            begin
                lit_s = 1'b1;
                hue_s = hue_scaled[11:4];
                val_s = FULL_VALUE;
            end
        end
        else
        begin
            hue_s = phase_reg;
            if (dist_w < rad_w)
            begin
                lit_s = 1'b1;
                val_s = FULL_VALUE;
            end
            else if (dist_w < rad_w + CMP_W'(256))
            begin
                lit_s = 1'b1;
                val_s = FULL_VALUE - edge_prod[15:8];
            end
            else if ((dist_w < rad_w + CMP_W'(768)) && !(x_reg[0] ^ y_reg[0])
                     && (rad_w > CMP_W'(512)))
            begin
                lit_s = 1'b1;
                val_s = GLOW_VALUE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shade)
        begin
            lit_reg <= lit_s;
            hue_reg <= hue_s;
            val_reg <= val_s;
        end
    end

    // ---------------- HSV to RGB, full saturation ----------------
    sector_t    sector_s;
    logic [7:0] sector_base;
    logic [5:0] hue_off;
    logic [7:0] frac;
    logic [7:0] frac_inv;
    logic [15:0] q_scale;
    logic [15:0] t_scale;
    sector_t    sector_reg;
    logic [7:0] kq_reg;
    logic [7:0] kt_reg;

    always_comb
    begin
        if (hue_reg < 8'(HUE_SPAN))
            sector_s = SEC_RED;
        else if (hue_reg < 8'(2 * HUE_SPAN))
            sector_s = SEC_YELLOW;
        else if (hue_reg < 8'(3 * HUE_SPAN))
            sector_s = SEC_GREEN;
        else if (hue_reg < 8'(4 * HUE_SPAN))
            sector_s = SEC_CYAN;
        else if (hue_reg < 8'(5 * HUE_SPAN))
            sector_s = SEC_BLUE;
        else
            sector_s = SEC_MAGENTA;
    end

    always_comb
    begin
        case (sector_s)
            SEC_RED:     sector_base = 8'(0);
            SEC_YELLOW:  sector_base = 8'(HUE_SPAN);
            SEC_GREEN:   sector_base = 8'(2 * HUE_SPAN);
            SEC_CYAN:    sector_base = 8'(3 * HUE_SPAN);
            SEC_BLUE:    sector_base = 8'(4 * HUE_SPAN);
            default:     sector_base = 8'(5 * HUE_SPAN);
        endcase
    end

    assign hue_off  = 6'(hue_reg - sector_base);
    assign frac     = 8'(hue_off) * 8'd6;
    assign frac_inv = 8'd255 - frac;
    assign q_scale  = {frac, 8'b0} - 16'(frac);
    assign t_scale  = {frac_inv, 8'b0} - 16'(frac_inv);

    always_ff @(posedge clk)
    begin
        if (cmd.hsv_a)
        begin
            sector_reg <= sector_s;
            kq_reg     <= 8'd255 - q_scale[15:8];
            kt_reg     <= 8'd255 - t_scale[15:8];
        end
    end

    logic [15:0] q_prod;
    logic [15:0] t_prod;
    logic [7:0]  q_val;
    logic [7:0]  t_val;
    logic [7:0]  red_s;
    logic [7:0]  green_s;
    logic [7:0]  blue_s;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        lit_fin_reg;

    assign q_prod = 16'(val_reg) * 16'(kq_reg);
    assign t_prod = 16'(val_reg) * 16'(kt_reg);
    assign q_val  = q_prod[15:8];
    assign t_val  = t_prod[15:8];

    always_comb
    begin
        red_s   = '0;
        green_s = '0;
        blue_s  = '0;
        if (lit_reg)
        begin
            case (sector_reg)
                SEC_RED:
                begin
                    red_s   = val_reg;
                    green_s = t_val;
                end
                SEC_YELLOW:
                begin
                    red_s   = q_val;
                    green_s = val_reg;
                end
                SEC_GREEN:
                begin
                    green_s = val_reg;
                    blue_s  = t_val;
                end
                SEC_CYAN:
                begin
                    green_s = q_val;
                    blue_s  = val_reg;
                end
                SEC_BLUE:
                begin
                    red_s   = t_val;
                    blue_s  = val_reg;
                end
                default:
                begin
                    red_s   = val_reg;
                    blue_s  = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hsv_b)
        begin
            red_reg     <= red_s;
            green_reg   <= green_s;
            blue_reg    <= blue_s;
            lit_fin_reg <= lit_reg;
        end
    end

    // ---------------- output register ----------------
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    logic        out_lit_reg;

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid_next  = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_lit_reg   <= lit_fin_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_red   = out_red_reg;
    assign pixel_green = out_green_reg;
    assign pixel_blue  = out_blue_reg;
    assign pixel_lit   = out_lit_reg;

endmodule : svpr_dp
`default_nettype wire
